>>> hw/rtl/pdr_pkg.sv
// Package with the shared types, constants and helper functions of the domain rescaler.
`default_nettype none
package pdr_pkg;

  localparam int WORD_W      = 64;
  localparam int FRAC_BITS   = 40;
  localparam int MAX_TERMS   = 8;
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = 6;
  localparam int IDX_W       = 3;
  localparam int TERMS_W     = 4;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TERMS_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TERMS_Y  = 3'd5;

  localparam logic signed [WORD_W-1:0] Q_ONE = 64'sh0000_0100_0000_0000;
  localparam logic signed [WORD_W-1:0] S_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WORD_W-1:0] S_MIN = 64'sh8000_0000_0000_0000;

  // Rows of Pascal's triangle up to the highest power a term can have.
  localparam logic [7:0] BINOM_TAB [8][8] = '{
    '{8'd1, 8'd0, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
    '{8'd1, 8'd1, 8'd0,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
    '{8'd1, 8'd2, 8'd1,  8'd0,  8'd0,  8'd0,  8'd0, 8'd0},
    '{8'd1, 8'd3, 8'd3,  8'd1,  8'd0,  8'd0,  8'd0, 8'd0},
    '{8'd1, 8'd4, 8'd6,  8'd4,  8'd1,  8'd0,  8'd0, 8'd0},
    '{8'd1, 8'd5, 8'd10, 8'd10, 8'd5,  8'd1,  8'd0, 8'd0},
    '{8'd1, 8'd6, 8'd15, 8'd20, 8'd15, 8'd6,  8'd1, 8'd0},
    '{8'd1, 8'd7, 8'd21, 8'd35, 8'd35, 8'd21, 8'd7, 8'd1}};

  typedef struct packed {
    logic signed [WORD_W-1:0] coeff_in;
    logic                     in_last;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] coeff_out;
    logic [IDX_W-1:0]         index_x;
    logic [IDX_W-1:0]         index_y;
    logic                     overflow;
    logic                     out_last;
  } out_item_t;

  typedef struct packed {
    logic                     start;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
    logic                     frac;
  } mul_req_t;

  typedef struct packed {
    logic                     busy;
    logic                     done;
    logic signed [WORD_W-1:0] res;
    logic                     ovf;
  } mul_rsp_t;

  function automatic logic signed [WORD_W-1:0] binom(input logic [IDX_W-1:0] n,
                                                     input logic [IDX_W-1:0] k);
    return $signed({56'd0, BINOM_TAB[n][k]});
  endfunction

  function automatic logic [WORD_W:0] add_sat(input logic signed [WORD_W-1:0] a,
                                              input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W-1:0] s;
    s = a + b;
    if ((a[WORD_W-1] == b[WORD_W-1]) && (s[WORD_W-1] != a[WORD_W-1])) begin
      return {1'b1, (a[WORD_W-1] ? S_MIN : S_MAX)};
    end
    return {1'b0, s};
  endfunction

  function automatic logic [TERMS_W-1:0] clamp_terms(input logic [TERMS_W-1:0] t);
    if (t == '0) begin
      return TERMS_W'(1);
    end
    if (t > TERMS_W'(MAX_TERMS)) begin
      return TERMS_W'(MAX_TERMS);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/pdr_ram.sv
// Generic simple dual-port RAM with a registered read port.
`default_nettype none
module pdr_ram #(
  parameter int WIDTH = pdr_pkg::WORD_W,
  parameter int DEPTH = pdr_pkg::STORE_DEPTH
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/pdr_mul.sv
// Shared multi-cycle Q23.40 multiplier with rounding and saturation.
`default_nettype none
module pdr_mul (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire pdr_pkg::mul_req_t req,
  output      pdr_pkg::mul_rsp_t rsp
);

  logic [63:0]  xm_r, ym_r;
  logic         neg_r, frac_r;
  logic [127:0] acc_r;
  logic [63:0]  pp_r;
  logic [1:0]   pps_r;
  logic [2:0]   cnt_r;
  logic         busy_r, done_r, ovf_r;
  logic [63:0]  res_r;

  logic [31:0]  xh, yh;
  logic [127:0] pp_ext;
  logic [63:0]  r;
  logic         big;

  assign xh     = cnt_r[1] ? xm_r[63:32] : xm_r[31:0];
  assign yh     = cnt_r[0] ? ym_r[63:32] : ym_r[31:0];
  assign pp_ext = {64'd0, pp_r} << {pps_r, 5'd0};
  assign r      = frac_r ? acc_r[103:40] : acc_r[63:0];
  assign big    = frac_r ? (|acc_r[127:104]) : (|acc_r[127:64]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        xm_r   <= req.a[63] ? 64'(-req.a) : 64'(req.a);
        ym_r   <= req.b[63] ? 64'(-req.b) : 64'(req.b);
        neg_r  <= req.a[63] ^ req.b[63];
        frac_r <= req.frac;
        acc_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        // Partial products are formed one per cycle and registered in pp_r before they are summed.
        if (cnt_r < 3'd4) begin
          pp_r  <= xh * yh;
          pps_r <= 2'({1'b0, cnt_r[1]} + {1'b0, cnt_r[0]});
        end
        if (cnt_r >= 3'd1 && cnt_r <= 3'd4) begin
          acc_r <= acc_r + pp_ext;
        end
        if (cnt_r == 3'd5 && frac_r) begin
          acc_r <= acc_r + (128'd1 << (pdr_pkg::FRAC_BITS - 1));
        end
        if (cnt_r == 3'd6) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          if (neg_r) begin
            if (big || (r[63] && (|r[62:0]))) begin
              res_r <= pdr_pkg::S_MIN;
              ovf_r <= 1'b1;
            end else begin
              res_r <= 64'(-r);
              ovf_r <= 1'b0;
            end
          end else begin
            if (big || r[63]) begin
              res_r <= pdr_pkg::S_MAX;
              ovf_r <= 1'b1;
            end else begin
              res_r <= r;
              ovf_r <= 1'b0;
            end
          end
        end
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = $signed(res_r);
  assign rsp.ovf  = ovf_r;

endmodule
`default_nettype wire

>>> hw/rtl/poly2d_domain_rescale.sv
// Top level of the 2D polynomial domain rescaler: configuration, sequencer and stores.
//
// Usage: software writes offset_x/y, scale_x/y (Q23.40) and terms_x/y through the
// cfg_ write port while the block is idle. The coefficient matrix then arrives on
// the in_ channel, one coefficient per transfer, x index fastest; in_last on the
// final transfer starts the computation. The rescaled matrix leaves on the out_
// channel in the same order, with its powers, a sticky saturation flag and
// out_last on the final coefficient. All multiplications run through one shared
// 64x64 multiplier built from a single 32x32 multiplier. For source term (i,j)
// the shift pass forms (j+1) binomial row products, (i+1)(j+1) binomial column
// products and i(j+1)+j offset power products. The scale pass adds one product
// per coefficient and one per scale power. in_stall stays high from in_last
// until the last result has been loaded into the output register. A stalled
// receiver holds the block in its output state; the result register keeps its
// transfer until taken.
// Reset (synchronous, active low) restores the register defaults, empties the
// load counter and drops any pending result.
`default_nettype none
module poly2d_domain_rescale (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [pdr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [pdr_pkg::WORD_W-1:0]           cfg_wdata,
  input  wire logic                                 in_valid,
  output      logic                                 in_stall,
  input  wire pdr_pkg::in_item_t                    in_data,
  output      logic                                 out_valid,
  input  wire logic                                 out_stall,
  output      pdr_pkg::out_item_t                   out_data
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_SRC_RD  = 5'd1;
  localparam logic [4:0] S_SRC_WT  = 5'd2;
  localparam logic [4:0] S_BY      = 5'd3;
  localparam logic [4:0] S_BY_W    = 5'd4;
  localparam logic [4:0] S_BX      = 5'd5;
  localparam logic [4:0] S_BX_W    = 5'd6;
  localparam logic [4:0] S_OX      = 5'd7;
  localparam logic [4:0] S_OX_W    = 5'd8;
  localparam logic [4:0] S_OY      = 5'd9;
  localparam logic [4:0] S_OY_W    = 5'd10;
  localparam logic [4:0] S_SC_RD   = 5'd11;
  localparam logic [4:0] S_SC_MUL  = 5'd12;
  localparam logic [4:0] S_SC_W    = 5'd13;
  localparam logic [4:0] S_SC_X    = 5'd14;
  localparam logic [4:0] S_SCX_W   = 5'd15;
  localparam logic [4:0] S_SC_Y    = 5'd16;
  localparam logic [4:0] S_SCY_W   = 5'd17;
  localparam logic [4:0] S_OUT_RD  = 5'd18;
  localparam logic [4:0] S_OUT_LD  = 5'd19;

  // Configuration registers.
  logic signed [63:0] offx_r, offy_r, sclx_r, scly_r;
  logic [3:0]         termsx_r, termsy_r;

  // Sequencer state.
  logic [4:0]         state_r;
  logic [6:0]         load_cnt_r;
  logic [3:0]         nx_r, ny_r;
  logic [2:0]         ix_r, iy_r, jx_r, jy_r;
  // offpx_r/offpy_r hold the offset power chains, and later the scale chains.
  logic signed [63:0] offpx_r, offpy_r;
  logic               tx_r, ty_r;
  logic [63:0]        vld_r, flag_r;

  logic               out_valid_r;
  pdr_pkg::out_item_t out_data_r;

  pdr_pkg::mul_req_t  mreq;
  pdr_pkg::mul_rsp_t  mrsp;

  logic               in_xfer, out_free;
  logic [6:0]         at_i_w, at_j_w;
  logic [5:0]         at_i, at_j;
  logic [63:0]        src_rdata, res_rdata, res_wdata;
  logic               res_we, res_re;
  logic [5:0]         res_waddr, res_raddr;
  logic signed [63:0] old_j, old_i;
  logic [64:0]        sum;
  logic               ix_more, iy_more, ty_new;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign at_i_w = 7'(ix_r) + 7'(iy_r) * 7'(nx_r);
  assign at_j_w = 7'(jx_r) + 7'(jy_r) * 7'(nx_r);
  assign at_i   = at_i_w[5:0];
  assign at_j   = at_j_w[5:0];

  assign ix_more = (4'(ix_r) + 4'd1) < nx_r;
  assign iy_more = (4'(iy_r) + 4'd1) < ny_r;
  assign ty_new  = ty_r | mrsp.ovf;

  // A result entry not yet touched in this computation reads as zero.
  assign old_j = vld_r[at_j] ? $signed(res_rdata) : 64'sd0;
  assign old_i = vld_r[at_i] ? $signed(res_rdata) : 64'sd0;
  assign sum   = pdr_pkg::add_sat(old_j, mrsp.res);

  pdr_ram #(.WIDTH(pdr_pkg::WORD_W), .DEPTH(pdr_pkg::STORE_DEPTH)) u_src (
    .clk   (clk),
    .we    (in_xfer && !load_cnt_r[6]),
    .waddr (load_cnt_r[5:0]),
    .wdata (in_data.coeff_in),
    .re    (state_r == S_SRC_RD),
    .raddr (at_i),
    .rdata (src_rdata)
  );

  assign res_re    = (state_r == S_BX) || (state_r == S_SC_RD) || (state_r == S_OUT_RD);
  assign res_raddr = (state_r == S_BX) ? at_j : at_i;
  assign res_we    = mrsp.done && ((state_r == S_BX_W) || (state_r == S_SC_W));
  assign res_waddr = (state_r == S_BX_W) ? at_j : at_i;
  assign res_wdata = (state_r == S_BX_W) ? sum[63:0] : mrsp.res;

  pdr_ram #(.WIDTH(pdr_pkg::WORD_W), .DEPTH(pdr_pkg::STORE_DEPTH)) u_res (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .re    (res_re),
    .raddr (res_raddr),
    .rdata (res_rdata)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = offpx_r;
    mreq.b     = offx_r;
    mreq.frac  = 1'b1;
    case (state_r)
      S_BY: begin
        mreq.start = 1'b1;
        mreq.a     = pdr_pkg::binom(iy_r, jy_r);
        mreq.b     = offpy_r;
        mreq.frac  = 1'b0;
      end
      S_BX: begin
        mreq.start = 1'b1;
        mreq.a     = pdr_pkg::binom(ix_r, jx_r);
        mreq.b     = offpx_r;
        mreq.frac  = 1'b0;
      end
      S_OX: begin
        mreq.start = 1'b1;
      end
      S_OY: begin
        mreq.start = 1'b1;
        mreq.a     = offpy_r;
        mreq.b     = offy_r;
      end
      S_SC_MUL: begin
        mreq.start = 1'b1;
        mreq.a     = old_i;
        mreq.b     = offpx_r;
      end
      S_SC_X: begin
        mreq.start = 1'b1;
        mreq.b     = sclx_r;
      end
      S_SC_Y: begin
        mreq.start = 1'b1;
        mreq.a     = offpy_r;
        mreq.b     = scly_r;
      end
      default: begin
        mreq.start = 1'b0;
      end
    endcase
  end

  pdr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offx_r      <= 64'sd0;
      offy_r      <= 64'sd0;
      sclx_r      <= pdr_pkg::Q_ONE;
      scly_r      <= pdr_pkg::Q_ONE;
      termsx_r    <= 4'd1;
      termsy_r    <= 4'd1;
      state_r     <= S_IDLE;
      load_cnt_r  <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pdr_pkg::REG_OFFSET_X: offx_r   <= $signed(cfg_wdata);
          pdr_pkg::REG_OFFSET_Y: offy_r   <= $signed(cfg_wdata);
          pdr_pkg::REG_SCALE_X:  sclx_r   <= $signed(cfg_wdata);
          pdr_pkg::REG_SCALE_Y:  scly_r   <= $signed(cfg_wdata);
          pdr_pkg::REG_TERMS_X:  termsx_r <= cfg_wdata[3:0];
          pdr_pkg::REG_TERMS_Y:  termsy_r <= cfg_wdata[3:0];
          default: ;
        endcase
      end

      // The output state reloads the register itself when it is taken.
      if (out_valid_r && !out_stall && (state_r != S_OUT_LD)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            if (in_data.in_last) begin
              load_cnt_r <= '0;
              nx_r       <= pdr_pkg::clamp_terms(termsx_r);
              ny_r       <= pdr_pkg::clamp_terms(termsy_r);
              vld_r      <= '0;
              flag_r     <= '0;
              ix_r       <= '0;
              iy_r       <= '0;
              state_r    <= S_SRC_RD;
            end else if (!load_cnt_r[6]) begin
              load_cnt_r <= load_cnt_r + 7'd1;
            end
          end
        end
        S_SRC_RD: state_r <= S_SRC_WT;
        S_SRC_WT: begin
          offpy_r <= $signed(src_rdata);
          ty_r    <= 1'b0;
          jy_r    <= iy_r;
          state_r <= S_BY;
        end
        S_BY: state_r <= S_BY_W;
        S_BY_W: begin
          if (mrsp.done) begin
            offpx_r <= mrsp.res;
            tx_r    <= ty_r | mrsp.ovf;
            jx_r    <= ix_r;
            state_r <= S_BX;
          end
        end
        S_BX: state_r <= S_BX_W;
        S_BX_W: begin
          if (mrsp.done) begin
            vld_r[at_j]  <= 1'b1;
            flag_r[at_j] <= flag_r[at_j] | mrsp.ovf | sum[64] | tx_r;
            if (jx_r != 3'd0) begin
              state_r <= S_OX;
            end else if (jy_r != 3'd0) begin
              state_r <= S_OY;
            end else if (ix_more) begin
              ix_r    <= ix_r + 3'd1;
              state_r <= S_SRC_RD;
            end else if (iy_more) begin
              ix_r    <= '0;
              iy_r    <= iy_r + 3'd1;
              state_r <= S_SRC_RD;
            end else begin
              // All contributions summed; start the scale pass at (0,0).
              ix_r    <= '0;
              iy_r    <= '0;
              offpx_r <= pdr_pkg::Q_ONE;
              offpy_r <= pdr_pkg::Q_ONE;
              tx_r    <= 1'b0;
              ty_r    <= 1'b0;
              state_r <= S_SC_RD;
            end
          end
        end
        S_OX: state_r <= S_OX_W;
        S_OX_W: begin
          if (mrsp.done) begin
            offpx_r <= mrsp.res;
            tx_r    <= tx_r | mrsp.ovf;
            jx_r    <= jx_r - 3'd1;
            state_r <= S_BX;
          end
        end
        S_OY: state_r <= S_OY_W;
        S_OY_W: begin
          if (mrsp.done) begin
            offpy_r <= mrsp.res;
            ty_r    <= ty_r | mrsp.ovf;
            jy_r    <= jy_r - 3'd1;
            state_r <= S_BY;
          end
        end
        S_SC_RD:  state_r <= S_SC_MUL;
        S_SC_MUL: state_r <= S_SC_W;
        S_SC_W: begin
          if (mrsp.done) begin
            vld_r[at_i]  <= 1'b1;
            flag_r[at_i] <= flag_r[at_i] | mrsp.ovf | tx_r;
            if (ix_more) begin
              state_r <= S_SC_X;
            end else if (iy_more) begin
              state_r <= S_SC_Y;
            end else begin
              ix_r    <= '0;
              iy_r    <= '0;
              state_r <= S_OUT_RD;
            end
          end
        end
        S_SC_X: state_r <= S_SCX_W;
        S_SCX_W: begin
          if (mrsp.done) begin
            offpx_r <= mrsp.res;
            tx_r    <= tx_r | mrsp.ovf;
            ix_r    <= ix_r + 3'd1;
            state_r <= S_SC_RD;
          end
        end
        S_SC_Y: state_r <= S_SCY_W;
        S_SCY_W: begin
          if (mrsp.done) begin
            // A new row restarts the x chain from the new y power.
            offpy_r <= mrsp.res;
            offpx_r <= mrsp.res;
            ty_r    <= ty_new;
            tx_r    <= ty_new;
            ix_r    <= '0;
            iy_r    <= iy_r + 3'd1;
            state_r <= S_SC_RD;
          end
        end
        S_OUT_RD: state_r <= S_OUT_LD;
        S_OUT_LD: begin
          if (out_free) begin
            out_valid_r          <= 1'b1;
            out_data_r.coeff_out <= old_i;
            out_data_r.index_x   <= ix_r;
            out_data_r.index_y   <= iy_r;
            out_data_r.overflow  <= flag_r[at_i];
            out_data_r.out_last  <= !ix_more && !iy_more;
            if (ix_more) begin
              ix_r    <= ix_r + 3'd1;
              state_r <= S_OUT_RD;
            end else if (iy_more) begin
              ix_r    <= '0;
              iy_r    <= iy_r + 3'd1;
              state_r <= S_OUT_RD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The load counter saturates at the store depth.
  a_load_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    load_cnt_r <= 7'(pdr_pkg::STORE_DEPTH))
    else $error("load counter beyond store depth");

  // The sequencer never restarts the shared multiplier while it is working.
  a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
    mreq.start |-> !mrsp.busy)
    else $error("multiplier started while busy");

  // No product is in flight once the block accepts new coefficients.
  a_idle_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mrsp.busy)
    else $error("multiplier busy while idle");

  // A result is loaded only into a free output register.
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT_LD && out_valid_r && out_stall) |=> $stable(out_data_r))
    else $error("output overwritten while stalled");
`endif

endmodule
`default_nettype wire

>>> tb/sv/tb_poly2d_domain_rescale.sv
// Self-checking testbench of the 2D polynomial domain rescaler with a scoreboard class.
`default_nettype none
module tb_poly2d_domain_rescale;
  timeunit 1ns;
  timeprecision 1ps;

  // The scoreboard keeps its own copy of the registers and the coefficient store.
  // Every accepted input transfer is fed to the rescale predictor, and every
  // in_last transfer queues the full predicted result matrix.
  class rescale_board;
    logic signed [pdr_pkg::WORD_W-1:0] ox, oy, sx, sy;
    logic [pdr_pkg::TERMS_W-1:0]       tx_raw, ty_raw;
    logic signed [pdr_pkg::WORD_W-1:0] store [pdr_pkg::STORE_DEPTH];
    int                                load_cnt;
    pdr_pkg::out_item_t                pending_q [$];
    int                                fails;

    function new();
      ox = '0;
      oy = '0;
      sx = pdr_pkg::Q_ONE;
      sy = pdr_pkg::Q_ONE;
      tx_raw = pdr_pkg::TERMS_W'(1);
      ty_raw = pdr_pkg::TERMS_W'(1);
      load_cnt = 0;
      fails = 0;
    endfunction

    function void write_reg(logic [pdr_pkg::CFG_IDX_W-1:0] idx,
                            logic [pdr_pkg::WORD_W-1:0] val);
      case (idx)
        pdr_pkg::REG_OFFSET_X: ox = val;
        pdr_pkg::REG_OFFSET_Y: oy = val;
        pdr_pkg::REG_SCALE_X:  sx = val;
        pdr_pkg::REG_SCALE_Y:  sy = val;
        pdr_pkg::REG_TERMS_X:  tx_raw = val[pdr_pkg::TERMS_W-1:0];
        pdr_pkg::REG_TERMS_Y:  ty_raw = val[pdr_pkg::TERMS_W-1:0];
        default: ;
      endcase
    endfunction

    static function int eff_terms(logic [pdr_pkg::TERMS_W-1:0] t);
      if (t == 0) return 1;
      if (t > pdr_pkg::MAX_TERMS) return pdr_pkg::MAX_TERMS;
      return int'(t);
    endfunction

    // Signed product, optionally rescaled by the fraction bits with rounding to
    // nearest (ties away from zero), saturated to 64 bits. Sets ovf on saturation.
    function logic signed [pdr_pkg::WORD_W-1:0] qmul(logic signed [pdr_pkg::WORD_W-1:0] a,
                                                     logic signed [pdr_pkg::WORD_W-1:0] b,
                                                     bit frac, inout bit ovf);
      logic [pdr_pkg::WORD_W-1:0] ma, mb, r;
      logic [127:0]               p;
      bit                         neg, big;
      neg = a[pdr_pkg::WORD_W-1] != b[pdr_pkg::WORD_W-1];
      ma = a[pdr_pkg::WORD_W-1] ? -a : a;
      mb = b[pdr_pkg::WORD_W-1] ? -b : b;
      p = {64'd0, ma} * {64'd0, mb};
      if (frac) begin
        p = p + (128'd1 << (pdr_pkg::FRAC_BITS - 1));
        r = p[pdr_pkg::FRAC_BITS +: pdr_pkg::WORD_W];
        big = |p[127:pdr_pkg::FRAC_BITS+pdr_pkg::WORD_W];
      end else begin
        r = p[pdr_pkg::WORD_W-1:0];
        big = |p[127:pdr_pkg::WORD_W];
      end
      if (neg) begin
        if (big || r > 64'h8000_0000_0000_0000) begin
          ovf = 1;
          return pdr_pkg::S_MIN;
        end
        return -r;
      end
      if (big || r[pdr_pkg::WORD_W-1]) begin
        ovf = 1;
        return pdr_pkg::S_MAX;
      end
      return r;
    endfunction

    function logic signed [pdr_pkg::WORD_W-1:0] qadd(logic signed [pdr_pkg::WORD_W-1:0] a,
                                                     logic signed [pdr_pkg::WORD_W-1:0] b,
                                                     inout bit ovf);
      logic signed [pdr_pkg::WORD_W-1:0] s;
      s = a + b;
      if (a[pdr_pkg::WORD_W-1] == b[pdr_pkg::WORD_W-1] &&
          s[pdr_pkg::WORD_W-1] != a[pdr_pkg::WORD_W-1]) begin
        ovf = 1;
        return a[pdr_pkg::WORD_W-1] ? pdr_pkg::S_MIN : pdr_pkg::S_MAX;
      end
      return s;
    endfunction

    // Taylor shift by the offsets followed by the power-of-scale weighting.
    function void rescale_matrix();
      logic signed [pdr_pkg::WORD_W-1:0] acc [pdr_pkg::STORE_DEPTH];
      bit                                flg [pdr_pkg::STORE_DEPTH];
      logic signed [pdr_pkg::WORD_W-1:0] offpy, offpx, term, scy, scx;
      bit                                ty, tx, t;
      int                                nx, ny, at;
      pdr_pkg::out_item_t                o;
      nx = eff_terms(tx_raw);
      ny = eff_terms(ty_raw);
      for (int k = 0; k < pdr_pkg::STORE_DEPTH; k++) begin
        acc[k] = '0;
        flg[k] = 0;
      end
      for (int iy = 0; iy < ny; iy++) begin
        for (int ix = 0; ix < nx; ix++) begin
          offpy = store[ix + iy * nx];
          ty = 0;
          for (int jy = iy; jy >= 0; jy--) begin
            tx = ty;
            offpx = qmul(pdr_pkg::BINOM_TAB[iy][jy], offpy, 0, tx);
            for (int jx = ix; jx >= 0; jx--) begin
              at = jx + jy * nx;
              t = 0;
              term = qmul(pdr_pkg::BINOM_TAB[ix][jx], offpx, 0, t);
              acc[at] = qadd(acc[at], term, t);
              flg[at] = flg[at] | t | tx;
              if (jx > 0) offpx = qmul(offpx, ox, 1, tx);
            end
            if (jy > 0) offpy = qmul(offpy, oy, 1, ty);
          end
        end
      end
      scy = pdr_pkg::Q_ONE;
      ty = 0;
      for (int iy = 0; iy < ny; iy++) begin
        scx = scy;
        tx = ty;
        for (int ix = 0; ix < nx; ix++) begin
          at = ix + iy * nx;
          t = 0;
          acc[at] = qmul(acc[at], scx, 1, t);
          flg[at] = flg[at] | t | tx;
          if (ix + 1 < nx) scx = qmul(scx, sx, 1, tx);
        end
        if (iy + 1 < ny) scy = qmul(scy, sy, 1, ty);
      end
      for (int k = 0; k < nx * ny; k++) begin
        o.coeff_out = acc[k];
        o.index_x = pdr_pkg::IDX_W'(k % nx);
        o.index_y = pdr_pkg::IDX_W'(k / nx);
        o.overflow = flg[k];
        o.out_last = (k + 1 == nx * ny);
        pending_q = {pending_q, o};
      end
    endfunction

    function void note_input(pdr_pkg::in_item_t it);
      if (load_cnt < pdr_pkg::STORE_DEPTH) begin
        store[load_cnt] = it.coeff_in;
        load_cnt++;
      end
      if (!it.in_last) return;
      load_cnt = 0;
      rescale_matrix();
    endfunction

    function void check_result(pdr_pkg::out_item_t got);
      pdr_pkg::out_item_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer coeff_out=%h", got.coeff_out);
        fails++;
        return;
      end
      want = pending_q.pop_front();
      if (got.coeff_out !== want.coeff_out) begin
        $error("coeff_out: expected %h, got %h", want.coeff_out, got.coeff_out);
        fails++;
      end
      if (got.index_x !== want.index_x) begin
        $error("index_x: expected %0d, got %0d", want.index_x, got.index_x);
        fails++;
      end
      if (got.index_y !== want.index_y) begin
        $error("index_y: expected %0d, got %0d", want.index_y, got.index_y);
        fails++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
        fails++;
      end
      if (got.out_last !== want.out_last) begin
        $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
        fails++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [pdr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pdr_pkg::WORD_W-1:0]    cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  pdr_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_stall;
  pdr_pkg::out_item_t            out_data;

  rescale_board board;
  bit           quiet;       // When set, neither side inserts idle cycles.
  bit           hold_req;    // Asks the receiver for one long hold-off.
  int           sent;
  int           filled;      // Highest count of store entries written so far.

  poly2d_domain_rescale DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver side: checks each result transfer and paces out_stall. The long
  // hold-off is counted here and outlasts a full 8x8 computation, so the block
  // reaches its output state while the sender keeps offering the next matrix.
  int stall_left, run_left, hold_left;
  initial begin
    stall_left = 0;
    run_left = 0;
    hold_left = 0;
  end
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      board.check_result(out_data);
    end
    if (hold_req) begin
      hold_req = 0;
      hold_left = 30000;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall <= 1'b0;
      run_left--;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap();
      run_left = $urandom_range(0, 12);
    end
  end

  task automatic cfg_write(input logic [pdr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pdr_pkg::WORD_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.write_reg(idx, val);
  endtask

  // One input transfer; valid stays high into the next item when no gap follows.
  task automatic send_coeff(input logic signed [pdr_pkg::WORD_W-1:0] c, input bit last);
    int                gap;
    pdr_pkg::in_item_t it;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.coeff_in = c;
    it.in_last = last;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.note_input(it);
    sent++;
  endtask

  // Block is idle once all results are out; a short pause covers the last
  // output register hand-off before any register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic signed [pdr_pkg::WORD_W-1:0] rand_coeff();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return $signed({$urandom, $urandom}) >>> 21;
    if (r < 85) return {$urandom, $urandom};
    if (r < 91) return pdr_pkg::S_MAX;
    if (r < 97) return pdr_pkg::S_MIN;
    return '0;
  endfunction

  function automatic logic signed [pdr_pkg::WORD_W-1:0] rand_param(input bit is_scale);
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $signed({$urandom, $urandom}) >>> 22;
    if (r < 72) return is_scale ? pdr_pkg::Q_ONE : '0;
    if (r < 84) return {$urandom, $urandom};
    if (r < 92) return pdr_pkg::S_MAX;
    return pdr_pkg::S_MIN;
  endfunction

  function automatic logic [pdr_pkg::WORD_W-1:0] rand_terms();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 92) return $urandom_range(4, pdr_pkg::MAX_TERMS);
    return {$urandom, $urandom};   // includes zero and values above the maximum
  endfunction

  // Sends count coefficients with in_last on the final one.
  task automatic send_matrix(input int count);
    for (int k = 0; k < count; k++) begin
      send_coeff(rand_coeff(), k == count - 1);
    end
    if (count > filled) filled = (count > pdr_pkg::STORE_DEPTH) ? pdr_pkg::STORE_DEPTH : count;
  endtask

  initial begin
    int  n, cnt, mat, reps;
    bit  long_done, hold_done;
    board = new();
    quiet = 0;
    hold_req = 0;
    sent = 0;
    filled = 0;
    long_done = 0;
    hold_done = 0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, 1x1 matrices with the field extremes.
    send_coeff(pdr_pkg::S_MAX, 1);
    send_coeff(pdr_pkg::S_MIN, 1);
    send_coeff('0, 1);
    filled = 1;
    wait_idle();
    // A 2x2 shift by (1.0, -1.0) with scales 2.0 and 0.5.
    cfg_write(pdr_pkg::REG_OFFSET_X, pdr_pkg::Q_ONE);
    cfg_write(pdr_pkg::REG_OFFSET_Y, -pdr_pkg::Q_ONE);
    cfg_write(pdr_pkg::REG_SCALE_X, pdr_pkg::Q_ONE <<< 1);
    cfg_write(pdr_pkg::REG_SCALE_Y, pdr_pkg::Q_ONE >>> 1);
    cfg_write(pdr_pkg::REG_TERMS_X, 64'd2);
    cfg_write(pdr_pkg::REG_TERMS_Y, 64'd2);
    send_coeff(pdr_pkg::Q_ONE, 0);
    send_coeff(-pdr_pkg::Q_ONE, 0);
    send_coeff(pdr_pkg::Q_ONE <<< 3, 0);
    send_coeff(pdr_pkg::S_MAX, 1);
    filled = 4;
    wait_idle();
    // Terms of zero acts as one, terms above the maximum as the maximum;
    // an extreme y scale and y offset force saturation along the chain.
    cfg_write(pdr_pkg::REG_TERMS_X, 64'd0);
    cfg_write(pdr_pkg::REG_TERMS_Y, 64'd9);
    cfg_write(pdr_pkg::REG_SCALE_Y, pdr_pkg::S_MAX);
    cfg_write(pdr_pkg::REG_OFFSET_Y, pdr_pkg::S_MAX);
    for (int k = 0; k < pdr_pkg::MAX_TERMS; k++) begin
      send_coeff(k[0] ? pdr_pkg::S_MIN : pdr_pkg::Q_ONE, k == pdr_pkg::MAX_TERMS - 1);
    end
    filled = pdr_pkg::MAX_TERMS;
    wait_idle();
    // 3x3 with the most negative offsets and scales.
    cfg_write(pdr_pkg::REG_TERMS_X, 64'd3);
    cfg_write(pdr_pkg::REG_TERMS_Y, 64'd3);
    cfg_write(pdr_pkg::REG_OFFSET_X, pdr_pkg::S_MIN);
    cfg_write(pdr_pkg::REG_OFFSET_Y, pdr_pkg::S_MIN);
    cfg_write(pdr_pkg::REG_SCALE_X, pdr_pkg::S_MIN);
    cfg_write(pdr_pkg::REG_SCALE_Y, pdr_pkg::S_MIN);
    send_matrix(9);
    wait_idle();

    // Random phases: a new setting, then a few matrices, mostly well formed.
    mat = 0;
    while (sent < 265) begin
      wait_idle();
      quiet = ($urandom_range(0, 5) == 0);
      cfg_write(pdr_pkg::REG_OFFSET_X, rand_param(0));
      cfg_write(pdr_pkg::REG_OFFSET_Y, rand_param(0));
      cfg_write(pdr_pkg::REG_SCALE_X, rand_param(1));
      cfg_write(pdr_pkg::REG_SCALE_Y, rand_param(1));
      cfg_write(pdr_pkg::REG_TERMS_X, rand_terms());
      cfg_write(pdr_pkg::REG_TERMS_Y, rand_terms());
      n = rescale_board::eff_terms(board.tx_raw) * rescale_board::eff_terms(board.ty_raw);
      reps = $urandom_range(2, 4);
      for (int r = 0; r < reps; r++) begin
        cnt = n;
        if (n > 1 && n <= filled && $urandom_range(0, 9) == 0) begin
          // Short matrix: the rest comes from earlier loads.
          cnt = $urandom_range(1, n - 1);
        end else if (!long_done && mat > 8) begin
          // Too many coefficients: those past the store depth are dropped.
          cnt = pdr_pkg::STORE_DEPTH + $urandom_range(1, 4);
          long_done = 1;
        end
        // Another matrix follows, so the sender keeps offering during the hold.
        if (!hold_done && mat >= 4 && r < reps - 1) begin
          hold_req = 1;
          hold_done = 1;
        end
        send_matrix(cnt);
        mat++;
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (board.fails == 0 && board.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire
